// File: design/tng_pkg.sv
package tng_pkg;

	localparam int GRID_BITS     = 11;
	localparam int RADIUS_BITS   = 2;
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [GRID_BITS-1:0]   GRID_WIDTH_RST  = 11'd1024;
	localparam logic [GRID_BITS-1:0]   GRID_HEIGHT_RST = 11'd1024;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RST      = 2'd1;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_RADIUS,
		REG_SHAPE_MODE
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_CHECK,
		ST_ROW,
		ST_EMIT
	} state_t;

endpackage

// File: design/tng_if.sv
interface tng_in_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;

	modport source(output valid, output center_x, output center_y, input ready);
	modport sink(input valid, input center_x, input center_y, output ready);
endinterface

interface tng_out_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] nbr_x;
	logic [COORD_BITS-1:0] nbr_y;
	logic                  last;
	logic                  error;

	modport source(output valid, output nbr_x, output nbr_y, output last, output error,
		input ready);
	modport sink(input valid, input nbr_x, input nbr_y, input last, input error,
		output ready);
endinterface

// File: design/toroidal_neighborhood_generator_top.sv
// Toroidal neighbourhood generator. Each centre cell word accepted on cell_in yields the
// wrapped coordinates of its neighbours on nbr_out, the final one marked with last, one
// word per cycle while nbr_out does not stall, with a row setup step between rows in
// square mode; a grid narrower or shorter than twice the radius yields a single error
// word instead, and cross mode at radius zero yields nothing. All coordinate arithmetic
// goes through one shared add, compare and correct unit: the centre is first reduced
// modulo the grid size by restoring division, one bit per cycle for each coordinate in
// turn, followed by a check step. Cross mode then emits 4*radius words; square mode
// emits 2*radius+1 rows, each a row setup step followed by 2*radius+1 result words.
// cell_in is ready only while no item is in progress; the last result may still wait in
// the output register. Configuration is written over the APB port and must only change
// while idle.
module toroidal_neighborhood_generator_top
	import tng_pkg::*;
#(
	parameter int MAX_RADIUS = 3,
	parameter int COORD_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	tng_in_if.sink                   cell_in,
	tng_out_if.source                nbr_out
);

	localparam int SW = COORD_BITS + 1;
	localparam int AW = COORD_BITS + 2;
	localparam int EW = (SW > GRID_BITS) ? SW : GRID_BITS;
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int KW = $clog2(2 * MAX_RADIUS + 1);
	localparam int DW = KW + 2;
	localparam int BW = $clog2(COORD_BITS);

	localparam logic [EW-1:0]          SIZE_LIM = EW'(1) << COORD_BITS;
	localparam logic [RADIUS_BITS-1:0] RMAX     = RADIUS_BITS'(MAX_RADIUS);
	localparam logic [BW-1:0]          BIT_LAST = BW'(COORD_BITS - 1);
	localparam logic signed [DW-1:0]   ONE_S    = DW'(1);

	logic [GRID_BITS-1:0]   grid_width_q;
	logic [GRID_BITS-1:0]   grid_height_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic                   shape_mode_q;

	state_t state_q, state_d;

	logic [COORD_BITS-1:0] div_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [BW-1:0]         bit_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [COORD_BITS-1:0] ry_q;
	logic                  half_q;
	logic [RW-1:0]         row_q;
	logic [KW-1:0]         col_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] nbr_x_q;
	logic [COORD_BITS-1:0] nbr_y_q;
	logic                  last_q;
	logic                  error_q;

	logic                  cfg_wr;
	reg_idx_t              reg_idx;
	logic [EW-1:0]         gw_ext, gh_ext;
	logic [SW-1:0]         w_eff, h_eff, two_r;
	logic [RW-1:0]         r_eff;
	logic                  too_small;
	logic                  slot_free;
	logic                  div_done;

	logic signed [AW-1:0]  u_a;
	logic [SW-1:0]         u_size;
	logic signed [AW-1:0]  u_size_s;
	logic signed [AW-1:0]  u_res;
	logic [COORD_BITS-1:0] u_coord;

	logic signed [DW-1:0]  k_s, r_s, row_s, d_s;
	logic [COORD_BITS-1:0] base_c;
	logic [1:0]            xphase;
	logic                  row_last;
	logic                  row_end;
	logic [COORD_BITS-1:0] emit_x, emit_y;
	logic                  emit_last;
	logic                  step_done;

	// Configuration registers.
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			radius_q      <= RADIUS_RST;
			shape_mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[GRID_BITS-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[GRID_BITS-1:0];
				REG_RADIUS:      radius_q      <= pwdata[RADIUS_BITS-1:0];
				REG_SHAPE_MODE:  shape_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GRID_WIDTH:  prdata = CFG_DATA_BITS'(grid_width_q);
			REG_GRID_HEIGHT: prdata = CFG_DATA_BITS'(grid_height_q);
			REG_RADIUS:      prdata = CFG_DATA_BITS'(radius_q);
			REG_SHAPE_MODE:  prdata = CFG_DATA_BITS'(shape_mode_q);
			default:         prdata = '0;
		endcase
	end

	// Effective grid sizes and radius.
	assign gw_ext = EW'(grid_width_q);
	assign gh_ext = EW'(grid_height_q);
	assign w_eff  = (gw_ext == '0) ? SW'(1) : ((gw_ext > SIZE_LIM) ? SW'(SIZE_LIM) : SW'(gw_ext));
	assign h_eff  = (gh_ext == '0) ? SW'(1) : ((gh_ext > SIZE_LIM) ? SW'(SIZE_LIM) : SW'(gh_ext));
	assign r_eff  = RW'((radius_q > RMAX) ? RMAX : radius_q);
	assign two_r  = SW'(r_eff) << 1;
	assign too_small = (w_eff < two_r) || (h_eff < two_r);

	assign slot_free = !out_valid_q || nbr_out.ready;
	assign div_done  = (bit_q == BIT_LAST);

	// Shared unit: brings an operand in the range -size..2*size-1 into 0..size-1.
	assign u_size_s = $signed({1'b0, u_size});
	assign u_res    = u_a[AW-1] ? (u_a + u_size_s) :
		((u_a >= u_size_s) ? (u_a - u_size_s) : u_a);
	assign u_coord  = u_res[COORD_BITS-1:0];

	// Operand selection and result formation.
	always_comb begin
		k_s       = $signed({2'b00, col_q});
		r_s       = $signed({{(DW-RW){1'b0}}, r_eff});
		row_s     = $signed({{(DW-RW){1'b0}}, row_q});
		xphase    = col_q[1:0];
		d_s       = '0;
		base_c    = cx_q;
		u_size    = w_eff;
		u_a       = $signed({1'b0, rem_q, div_q[COORD_BITS-1]});
		emit_x    = u_coord;
		emit_y    = ry_q;
		emit_last = 1'b0;
		row_last  = (half_q && (row_q == r_eff)) || (r_eff == '0);
		row_end   = 1'b0;
		step_done = 1'b0;
		case (state_q)
			ST_DIV_X: begin
				u_size = w_eff;
			end
			ST_DIV_Y: begin
				u_size = h_eff;
			end
			ST_ROW: begin
				base_c = cy_q;
				u_size = h_eff;
				d_s    = half_q ? -row_s : row_s;
				u_a    = $signed({2'b00, base_c}) + {{(AW-DW){d_s[DW-1]}}, d_s};
			end
			ST_EMIT: begin
				if (shape_mode_q) begin
					if (k_s < r_s) begin
						d_s = -(k_s + ONE_S);
					end else if (k_s < (r_s <<< 1)) begin
						d_s = k_s - r_s + ONE_S;
					end else begin
						d_s = '0;
					end
					base_c    = cx_q;
					u_size    = w_eff;
					emit_x    = u_coord;
					emit_y    = ry_q;
					row_end   = (k_s == (r_s <<< 1));
					emit_last = row_last && row_end;
				end else begin
					d_s    = ((xphase == 2'd0) || (xphase == 2'd3)) ? -row_s : row_s;
					base_c = xphase[1] ? cy_q : cx_q;
					u_size = xphase[1] ? h_eff : w_eff;
					emit_x = xphase[1] ? cx_q : u_coord;
					emit_y = xphase[1] ? u_coord : cy_q;
					row_end   = (xphase == 2'd3);
					emit_last = row_end && (row_q == r_eff);
				end
				u_a       = $signed({2'b00, base_c}) + {{(AW-DW){d_s[DW-1]}}, d_s};
				step_done = slot_free && emit_last;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cell_in.valid) state_d = ST_DIV_X;
			end
			ST_DIV_X: begin
				if (div_done) state_d = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (div_done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (too_small) begin
					if (slot_free) state_d = ST_IDLE;
				end else if (shape_mode_q) begin
					state_d = ST_ROW;
				end else if (r_eff == '0) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_ROW: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (step_done) begin
					state_d = ST_IDLE;
				end else if (slot_free && row_end && shape_mode_q) begin
					state_d = ST_ROW;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_q   <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			ry_q    <= '0;
			half_q  <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (cell_in.valid) begin
						div_q <= cell_in.center_x;
						cy_q  <= cell_in.center_y;
						rem_q <= '0;
						bit_q <= '0;
					end
				end
				ST_DIV_X: begin
					if (div_done) begin
						cx_q  <= u_coord;
						div_q <= cy_q;
						rem_q <= '0;
						bit_q <= '0;
					end else begin
						rem_q <= u_coord;
						div_q <= div_q << 1;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_DIV_Y: begin
					if (div_done) begin
						cy_q <= u_coord;
					end else begin
						rem_q <= u_coord;
						div_q <= div_q << 1;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_CHECK: begin
					half_q <= 1'b0;
					col_q  <= '0;
					row_q  <= shape_mode_q ? RW'(0) : RW'(1);
				end
				ST_ROW: begin
					ry_q  <= u_coord;
					col_q <= '0;
				end
				ST_EMIT: begin
					if (slot_free && !emit_last) begin
						if (row_end) begin
							col_q <= '0;
							if (shape_mode_q && !half_q && (row_q == r_eff)) begin
								half_q <= 1'b1;
								row_q  <= RW'(1);
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if ((state_q == ST_CHECK) && too_small && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (nbr_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && slot_free) begin
			nbr_x_q <= emit_x;
			nbr_y_q <= emit_y;
			last_q  <= emit_last;
			error_q <= 1'b0;
		end else if ((state_q == ST_CHECK) && too_small && slot_free) begin
			nbr_x_q <= '0;
			nbr_y_q <= '0;
			last_q  <= 1'b1;
			error_q <= 1'b1;
		end
	end

	assign cell_in.ready = (state_q == ST_IDLE);
	assign nbr_out.valid = out_valid_q;
	assign nbr_out.nbr_x = nbr_x_q;
	assign nbr_out.nbr_y = nbr_y_q;
	assign nbr_out.last  = last_q;
	assign nbr_out.error = error_q;

`ifndef SYNTHESIS
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_out.valid && nbr_out.error |->
		(nbr_out.nbr_x == '0) && (nbr_out.nbr_y == '0) && nbr_out.last)
		else $error("error word must carry zero coordinates and last");
	a_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_out.valid && !nbr_out.error |->
		(SW'(nbr_out.nbr_x) < w_eff) && (SW'(nbr_out.nbr_y) < h_eff))
		else $error("neighbour coordinate outside the grid");
	a_centre_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> (SW'(cx_q) < w_eff) && (SW'(cy_q) < h_eff))
		else $error("centre not reduced into the grid");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cell_in.valid && cell_in.ready |=> state_q == ST_DIV_X)
		else $error("accepted word did not start the reduction");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_out.valid && !nbr_out.ready |=> nbr_out.valid)
		else $error("pending result dropped");
`endif

endmodule

// File: tb/tb_toroidal_neighborhood_generator_top.sv
`timescale 1ns / 100ps

module tb_toroidal_neighborhood_generator_top
	import tng_pkg::*;
();

	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 150;
	localparam int DIR_ROWS      = 38;
	localparam int TYPED_WORDS   = 16;
	localparam int SEGMENTS      = 8;
	localparam int SEG_CELLS     = 26;
	localparam int PRESS_CELLS   = 8;

	typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_t;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic       last;
		logic       err;
	} nbr_word_t;

	typedef struct packed {
		row_kind_t  kind;
		reg_idx_t   idx;
		logic [31:0] value;
		logic [9:0] cx;
		logic [9:0] cy;
		int         n_typed;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	tng_in_if  #(.COORD_BITS(10)) cell_in ();
	tng_out_if #(.COORD_BITS(10)) nbr_out ();

	toroidal_neighborhood_generator_top #(
		.MAX_RADIUS(3),
		.COORD_BITS(10)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cell_in (cell_in),
		.nbr_out (nbr_out)
	);

	logic [10:0] cfg_width  = 11'd1024;
	logic [10:0] cfg_height = 11'd1024;
	logic [1:0]  cfg_radius = 2'd1;
	logic        cfg_shape  = 1'b0;

	nbr_word_t expected_nbrs [$];
	int        fault_count  = 0;
	int        cells_sent   = 0;
	int        words_seen   = 0;
	int        reg_writes   = 0;
	int        tx_idle_pct  = 0;
	int        rx_stall_pct = 0;
	logic      hold_req     = 1'b0;

	nbr_word_t typed_words [TYPED_WORDS] = '{
		'{10'd1023, 10'd0,    1'b0, 1'b0},
		'{10'd1,    10'd0,    1'b0, 1'b0},
		'{10'd0,    10'd1,    1'b0, 1'b0},
		'{10'd0,    10'd1023, 1'b1, 1'b0},
		'{10'd1022, 10'd1023, 1'b0, 1'b0},
		'{10'd0,    10'd1023, 1'b0, 1'b0},
		'{10'd1023, 10'd0,    1'b0, 1'b0},
		'{10'd1023, 10'd1022, 1'b1, 1'b0},
		'{10'd5,    10'd7,    1'b1, 1'b0},
		'{10'd0,    10'd3,    1'b1, 1'b0},
		'{10'd0,    10'd0,    1'b1, 1'b1},
		'{10'd0,    10'd0,    1'b1, 1'b1},
		'{10'd0,    10'd0,    1'b1, 1'b1},
		'{10'd0,    10'd0,    1'b1, 1'b1},
		'{10'd0,    10'd0,    1'b1, 1'b1},
		'{10'd0,    10'd0,    1'b1, 1'b1}
	};

	// A count of -1 means the words are worked out by the predictor.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd0,    10'd0,    4},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd1023, 4},
		'{ROW_WRITE, REG_RADIUS,      32'd0,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd5,    10'd7,    0},
		'{ROW_WRITE, REG_SHAPE_MODE,  32'd1,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd5,    10'd7,    1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd1,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd3,    1},
		'{ROW_WRITE, REG_RADIUS,      32'd1,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd9,    10'd9,    1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd0,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd1023, 1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd2047, 10'd0,    10'd0,    0},
		'{ROW_WRITE, REG_GRID_HEIGHT, 32'd2,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd1023, -1},
		'{ROW_WRITE, REG_GRID_HEIGHT, 32'd0,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd0,    10'd0,    1},
		'{ROW_WRITE, REG_GRID_HEIGHT, 32'd6,    10'd0,    10'd0,    0},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd6,    10'd0,    10'd0,    0},
		'{ROW_WRITE, REG_RADIUS,      32'd3,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd5,    10'd0,    -1},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd1023, -1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd5,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd2,    10'd2,    1},
		'{ROW_WRITE, REG_SHAPE_MODE,  32'd0,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd2,    10'd2,    1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd1024, 10'd0,    10'd0,    0},
		'{ROW_WRITE, REG_GRID_HEIGHT, 32'd1024, 10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd0,    -1},
		'{ROW_WRITE, REG_RADIUS,      32'd2,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd512,  10'd1,    -1},
		'{ROW_WRITE, REG_GRID_HEIGHT, 32'd1025, 10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd3,    10'd1023, -1},
		'{ROW_WRITE, REG_GRID_WIDTH,  32'd3,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd682,  10'd341,  1},
		'{ROW_WRITE, REG_SHAPE_MODE,  32'd1,    10'd0,    10'd0,    0},
		'{ROW_WRITE, REG_RADIUS,      32'd1,    10'd0,    10'd0,    0},
		'{ROW_CELL,  REG_GRID_WIDTH,  32'd0,    10'd1023, 10'd1023, -1}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Run timed out with %0d words still expected.", expected_nbrs.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	function automatic int eff_size(input logic [10:0] size_reg);
		if (size_reg == 11'd0)
			return 1;
		if (size_reg > 11'd1024)
			return 1024;
		return int'(size_reg);
	endfunction

	function automatic logic [9:0] wrap_coord(input int c, input int d, input int size);
		return 10'((c + d + 4 * size) % size);
	endfunction

	function automatic void queue_word(input nbr_word_t w);
		expected_nbrs = {expected_nbrs, w};
	endfunction

	function automatic void push_nbr(input int x, input int y, input logic last);
		queue_word('{10'(x), 10'(y), last, 1'b0});
	endfunction

	function automatic void predict_neighbours(input logic [9:0] px, input logic [9:0] py);
		int w;
		int h;
		int r;
		int cx;
		int cy;
		int ry;
		int total;
		int k;
		w = eff_size(cfg_width);
		h = eff_size(cfg_height);
		r = int'(cfg_radius);
		cx = int'(px) % w;
		cy = int'(py) % h;
		if (w < 2 * r || h < 2 * r) begin
			queue_word('{10'd0, 10'd0, 1'b1, 1'b1});
			return;
		end
		k = 0;
		if (!cfg_shape) begin
			total = 4 * r;
			for (int i = 1; i <= r; i++) begin
				push_nbr(wrap_coord(cx, -i, w), cy, 1'b0);
				push_nbr(wrap_coord(cx, i, w), cy, 1'b0);
				push_nbr(cx, wrap_coord(cy, i, h), 1'b0);
				k += 4;
				push_nbr(cx, wrap_coord(cy, -i, h), k == total);
			end
		end else begin
			total = (2 * r + 1) * (2 * r + 1);
			for (int hf = 0; hf < 2; hf++) begin
				for (int i = hf; i <= r; i++) begin
					ry = wrap_coord(cy, (hf != 0) ? -i : i, h);
					for (int j = 1; j <= r; j++)
						push_nbr(wrap_coord(cx, -j, w), ry, 1'b0);
					for (int j = 1; j <= r; j++)
						push_nbr(wrap_coord(cx, j, w), ry, 1'b0);
					k += 2 * r + 1;
					push_nbr(cx, ry, k == total);
				end
			end
		end
	endfunction

	task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		apb_xfer(1'b1, idx, value, rd);
		case (idx)
			REG_GRID_WIDTH:  cfg_width  = value[10:0];
			REG_GRID_HEIGHT: cfg_height = value[10:0];
			REG_RADIUS:      cfg_radius = value[1:0];
			REG_SHAPE_MODE:  cfg_shape  = value[0];
			default: ;
		endcase
		case (idx)
			REG_GRID_WIDTH:  want = 32'(cfg_width);
			REG_GRID_HEIGHT: want = 32'(cfg_height);
			REG_RADIUS:      want = 32'(cfg_radius);
			default:         want = 32'(cfg_shape);
		endcase
		reg_writes++;
		apb_xfer(1'b0, idx, 32'd0, rd);
		if (rd !== want)
			flag_fault($sformatf("register %s read back %0h, expected %0h", idx.name(), rd,
				want));
	endtask

	task automatic send_cell(input logic [9:0] cx, input logic [9:0] cy, input int n_typed,
		input int base);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			cell_in.valid = 1'b0;
			@(negedge clk);
		end
		cell_in.valid    = 1'b1;
		cell_in.center_x = cx;
		cell_in.center_y = cy;
		@(posedge clk);
		while (!cell_in.ready)
			@(posedge clk);
		if (n_typed < 0)
			predict_neighbours(cx, cy);
		else
			for (int k = 0; k < n_typed; k++)
				queue_word(typed_words[base + k]);
		cells_sent++;
	endtask

	// Drops valid, waits for every outstanding word and lets a word-less item finish.
	task automatic wait_idle();
		@(negedge clk);
		cell_in.valid = 1'b0;
		while (expected_nbrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1:       begin tx_idle_pct = 66; rx_stall_pct = 0;  end
			2:       begin tx_idle_pct = 0;  rx_stall_pct = 66; end
			3:       begin tx_idle_pct = 21; rx_stall_pct = 21; end
			default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
		endcase
	endtask

	function automatic logic [31:0] pick_size();
		case ($urandom_range(9))
			0:       return 32'd0;
			1:       return 32'd1;
			2, 3:    return $urandom_range(8, 2);
			4:       return $urandom_range(64, 9);
			5:       return 32'd1024;
			6:       return $urandom_range(2047, 1025);
			default: return $urandom_range(1023, 65);
		endcase
	endfunction

	function automatic logic [9:0] pick_centre(input logic [10:0] size_reg);
		case ($urandom_range(3))
			0:       return 10'd0;
			1:       return 10'(eff_size(size_reg) - 1);
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		nbr_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nbr_out.ready = 1'b0;
			end else begin
				nbr_out.ready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		nbr_word_t got;
		nbr_word_t want;
		if (arst_n && nbr_out.valid && nbr_out.ready) begin
			got = {nbr_out.nbr_x, nbr_out.nbr_y, nbr_out.last, nbr_out.error};
			words_seen++;
			if (expected_nbrs.size() == 0) begin
				flag_fault($sformatf("unexpected word x=%0d y=%0d last=%0b error=%0b",
					got.x, got.y, got.last, got.err));
			end else begin
				want = expected_nbrs.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
					got.err !== want.err)
					flag_fault($sformatf({"word mismatch: expected x=%0d y=%0d last=%0b ",
						"error=%0b, got x=%0d y=%0d last=%0b error=%0b"}, want.x, want.y,
						want.last, want.err, got.x, got.y, got.last, got.err));
			end
		end
	end

	initial begin
		int typed_pos;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cell_in.valid    = 1'b0;
		cell_in.center_x = '0;
		cell_in.center_y = '0;
		typed_pos        = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		set_idling(3);
		for (int n = 0; n < DIR_ROWS; n++) begin
			if (dir_rows[n].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(dir_rows[n].idx, dir_rows[n].value);
			end else begin
				send_cell(dir_rows[n].cx, dir_rows[n].cy, dir_rows[n].n_typed, typed_pos);
				if (dir_rows[n].n_typed > 0)
					typed_pos += dir_rows[n].n_typed;
			end
		end

		// Output held off while full windows keep arriving, so the input side backs up.
		wait_idle();
		set_idling(0);
		write_reg(REG_GRID_WIDTH, 32'd1024);
		write_reg(REG_GRID_HEIGHT, 32'd1024);
		write_reg(REG_RADIUS, 32'd3);
		write_reg(REG_SHAPE_MODE, 32'd1);
		hold_req = ~hold_req;
		for (int n = 0; n < PRESS_CELLS; n++)
			send_cell(10'($urandom_range(1023)), 10'($urandom_range(1023)), -1, 0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			set_idling(seg % 4);
			write_reg(REG_GRID_WIDTH, pick_size());
			write_reg(REG_GRID_HEIGHT, pick_size());
			write_reg(REG_RADIUS, $urandom_range(3));
			write_reg(REG_SHAPE_MODE, $urandom_range(1));
			for (int n = 0; n < SEG_CELLS; n++) begin
				if (seg == 5 && n == SEG_CELLS / 2)
					wait_idle();
				send_cell(pick_centre(cfg_width), pick_centre(cfg_height), -1, 0);
			end
		end

		wait_idle();
		if (expected_nbrs.size() != 0)
			flag_fault($sformatf("%0d words never arrived", expected_nbrs.size()));
		$display("Sent %0d centre cells under %0d register writes and checked %0d words.",
			cells_sent, reg_writes, words_seen);
		$display("Covered both shapes, every radius, grid edge cases and all idling mixes.");
		if (fault_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches in total.", fault_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
